### sv/rscs_pkg.sv
// Shared opcodes, function codes and execute result type for the subset core.
package rscs_pkg;

  localparam logic [6:0] OP_REG    = 7'd51;
  localparam logic [6:0] OP_IMM    = 7'd19;
  localparam logic [6:0] OP_LOAD   = 7'd3;
  localparam logic [6:0] OP_STORE  = 7'd35;
  localparam logic [6:0] OP_BRANCH = 7'd99;
  localparam logic [6:0] OP_JALR   = 7'd103;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_JALR = 3'd0;

  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_ALT  = 7'd32;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned REG_AW  = 5;
  localparam int unsigned OUT_W   = 72;

  typedef struct packed {
    logic [XLEN-1:0]   npc;
    logic              wr;
    logic [REG_AW-1:0] rd;
    logic [XLEN-1:0]   val;
    logic              mw;
    logic              halt;
    logic              load;
    logic [XLEN-1:0]   addr;
    logic [XLEN-1:0]   sdata;
  } ex_res_t;

endpackage

### sv/riscv_subset_core_step.sv
// Top level of the subset core: register file and data memory pipeline.
// Each word passes through the s1, s2 and output registers before its result is on out_*.
// Throughput: one word per cycle unless out_tready or the reset sweep stalls, loads included;
// a load result feeds the next word through a forward from the data memory read port.
// Reset: PC, halt flag, register and pipeline valid bits clear at once; the data memory is then
// swept to zero at one entry a cycle, all DMEM_DEPTH entries, with in_tready low.
module riscv_subset_core_step #(
  parameter int DMEM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] instruction_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [31:0] next_pc, [32] reg_written, [37:33] dest_index,
                                  // [69:38] dest_value, [70] mem_written, [71] halted
);

  localparam int DAW = $clog2(DMEM_DEPTH);

  logic                in_acc;
  logic                s1_adv;
  logic                s2_adv;

  logic                clr_busy_r;
  logic [DAW-1:0]      clr_cnt_r;

  logic [31:0]         pc_r;
  logic                stopped_r;
  logic [31:0]         rf_ok_r;

  logic                s1_valid_r;
  logic [31:0]         s1_word_r;
  logic                s1_a_byp_r, s1_b_byp_r;
  logic [31:0]         s1_a_bval_r, s1_b_bval_r;
  logic                s1_a_ok_r, s1_b_ok_r;

  logic                s2_valid_r;
  logic [31:0]         s2_npc_r;
  logic                s2_wr_r;
  logic [4:0]          s2_rd_r;
  logic [31:0]         s2_val_r;
  logic                s2_mw_r;
  logic                s2_halt_r;
  logic                s2_load_r;

  logic                out_valid_r;
  logic [71:0]         out_data_r;

  logic [31:0]         rf_a_q, rf_b_q, dmem_q;
  logic                rf_we;
  logic [31:0]         s2_fin;
  logic [31:0]         opa, opb;
  rscs_pkg::ex_res_t   ex;

  logic                dm_we;
  logic [DAW-1:0]      dm_waddr;
  logic [31:0]         dm_wdata;
  logic                dm_re;

  assign s2_adv    = s2_valid_r && (!out_valid_r || out_tready);
  assign s1_adv    = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_tready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  assign s2_fin = s2_load_r ? dmem_q : s2_val_r;
  assign rf_we  = s2_adv && s2_wr_r;

  rscs_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(s2_rd_r), .wdata(s2_fin),
    .re(in_acc), .raddr(in_tdata[19:15]), .rdata(rf_a_q)
  );

  rscs_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(s2_rd_r), .wdata(s2_fin),
    .re(in_acc), .raddr(in_tdata[24:20]), .rdata(rf_b_q)
  );

  always_comb begin
    if (s2_valid_r && s2_wr_r && s2_rd_r == s1_word_r[19:15]) begin
      opa = s2_fin;
    end else if (s1_a_byp_r) begin
      opa = s1_a_bval_r;
    end else begin
      opa = s1_a_ok_r ? rf_a_q : 32'd0;
    end
    if (s2_valid_r && s2_wr_r && s2_rd_r == s1_word_r[24:20]) begin
      opb = s2_fin;
    end else if (s1_b_byp_r) begin
      opb = s1_b_bval_r;
    end else begin
      opb = s1_b_ok_r ? rf_b_q : 32'd0;
    end
  end

  rscs_exec u_exec (
    .word(s1_word_r), .pc(pc_r), .stopped(stopped_r),
    .opa(opa), .opb(opb), .res(ex)
  );

  assign dm_we    = clr_busy_r || (s1_adv && ex.mw);
  assign dm_waddr = clr_busy_r ? clr_cnt_r : ex.addr[DAW-1:0];
  assign dm_wdata = clr_busy_r ? 32'd0 : ex.sdata;
  assign dm_re    = s1_adv && ex.load;

  rscs_ram #(.WIDTH(32), .DEPTH(DMEM_DEPTH)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(dm_re), .raddr(ex.addr[DAW-1:0]), .rdata(dmem_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      stopped_r   <= 1'b0;
      rf_ok_r     <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == DAW'(DMEM_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (rf_we) begin
        rf_ok_r[s2_rd_r] <= 1'b1;
      end
      if (s1_adv) begin
        pc_r      <= ex.npc;
        stopped_r <= ex.halt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r   <= in_tdata;
      s1_a_byp_r  <= rf_we && s2_rd_r == in_tdata[19:15];
      s1_b_byp_r  <= rf_we && s2_rd_r == in_tdata[24:20];
      s1_a_bval_r <= s2_fin;
      s1_b_bval_r <= s2_fin;
      s1_a_ok_r   <= rf_ok_r[in_tdata[19:15]];
      s1_b_ok_r   <= rf_ok_r[in_tdata[24:20]];
    end
    if (s1_adv) begin
      s2_npc_r  <= ex.npc;
      s2_wr_r   <= ex.wr;
      s2_rd_r   <= ex.rd;
      s2_val_r  <= ex.val;
      s2_mw_r   <= ex.mw;
      s2_halt_r <= ex.halt;
      s2_load_r <= ex.load;
    end
    if (s2_adv) begin
      out_data_r <= {s2_halt_r, s2_mw_r, s2_fin, s2_rd_r, s2_wr_r, s2_npc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### sv/rscs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rscs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/rscs_exec.sv
// Decode and execute of one instruction word on forwarded register operands.
module rscs_exec (
  input  logic [31:0]     word,
  input  logic [31:0]     pc,
  input  logic            stopped,
  input  logic [31:0]     opa,
  input  logic [31:0]     opb,
  output rscs_pkg::ex_res_t res
);

  always_comb begin
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic        wr;
    logic        ld;
    logic [31:0] val;
    op    = word[6:0];
    f3    = word[14:12];
    f7    = word[31:25];
    imm_i = {{20{word[31]}}, word[31:20]};
    imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    wr    = 1'b0;
    ld    = 1'b0;
    val   = '0;
    res       = '0;
    res.npc   = pc + 32'd4;
    res.rd    = word[11:7];
    res.sdata = opb;
    res.addr  = opa + imm_i;
    unique case (op)
      rscs_pkg::OP_REG: begin
        unique case ({f7, f3})
          {rscs_pkg::F7_BASE, rscs_pkg::F3_ADD}: begin val = opa + opb; wr = 1'b1; end
          {rscs_pkg::F7_ALT,  rscs_pkg::F3_ADD}: begin val = opa - opb; wr = 1'b1; end
          {rscs_pkg::F7_BASE, rscs_pkg::F3_AND}: begin val = opa & opb; wr = 1'b1; end
          {rscs_pkg::F7_BASE, rscs_pkg::F3_XOR}: begin val = opa ^ opb; wr = 1'b1; end
          {rscs_pkg::F7_ALT,  rscs_pkg::F3_SR}: begin
            val = $unsigned($signed(opa) >>> opb[4:0]);
            wr  = 1'b1;
          end
          default: ;
        endcase
      end
      rscs_pkg::OP_IMM: begin
        if (f3 == rscs_pkg::F3_ADD) begin
          val = opa + imm_i;
          wr  = 1'b1;
        end else if (f3 == rscs_pkg::F3_AND) begin
          val = opa & imm_i;
          wr  = 1'b1;
        end
      end
      rscs_pkg::OP_LOAD: begin
        if (f3 == rscs_pkg::F3_WORD) begin
          wr = 1'b1;
          ld = 1'b1;
        end
      end
      rscs_pkg::OP_STORE: begin
        if (f3 == rscs_pkg::F3_WORD) begin
          res.addr = opa + imm_s;
          res.mw   = 1'b1;
        end
      end
      rscs_pkg::OP_BRANCH: begin
        if (f3 == rscs_pkg::F3_BLT && $signed(opa) < $signed(opb)) begin
          res.npc = pc + imm_b;
        end
      end
      rscs_pkg::OP_JALR: begin
        if (f3 == rscs_pkg::F3_JALR) begin
          val     = pc + 32'd4;
          wr      = 1'b1;
          res.npc = opa + imm_i;
        end
      end
      default: ;
    endcase
    if (stopped || word == 32'd0) begin
      res.npc  = pc;
      res.halt = 1'b1;
      res.mw   = 1'b0;
      res.rd   = '0;
    end else if (wr && word[11:7] != 5'd0) begin
      res.wr   = 1'b1;
      res.val  = val;
      res.load = ld;
    end else begin
      res.rd = '0;
    end
  end

endmodule

### sv/rscs_chk.sv
// Port-level checker for the subset core, bound to the top level.
module rscs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[71] |-> !out_tdata[32] && !out_tdata[70])
    else $error("halted word carries a write");

  a_no_wr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[37:33] == 5'd0 && out_tdata[69:38] == 32'd0)
    else $error("no write but destination fields not zero");

  a_wr_not_x0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[37:33] != 5'd0 && !out_tdata[70])
    else $error("register write to x0 or together with a store");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

endmodule

bind riscv_subset_core_step rscs_chk u_rscs_chk (
  .clk(clk),
  .rst_n(rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking streaming testbench for riscv_subset_core_step with an in-line predictor.
module testbench;

  localparam int unsigned MEM_WORDS = 4096;
  localparam logic [6:0]  F7_ODD    = 7'd1;
  localparam logic [2:0]  F3_SLL    = 3'd1;

  typedef struct packed {
    logic        halted;
    logic        mem_written;
    logic [31:0] dest_value;
    logic [4:0]  dest_index;
    logic        reg_written;
    logic [31:0] next_pc;
  } retire_t;

  typedef enum int {
    K_ADD, K_SUB, K_AND, K_XOR, K_SRA, K_ADDI, K_ANDI,
    K_LW, K_SW, K_BLT, K_JALR, K_ODD, K_NOISE
  } insn_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  logic [31:0] core_pc;
  logic [31:0] core_regs [32];
  logic [31:0] core_mem [MEM_WORDS];
  logic        core_stopped;

  retire_t retire_q[$];
  int      mismatch_count = 0;
  int      words_sent = 0;
  int      n_reg_writes = 0;
  int      n_loads = 0;
  int      n_stores = 0;
  int      n_taken = 0;
  int      n_jumps = 0;
  int      n_halted = 0;

  logic tx_low = 1'b1;
  logic tx_steady = 1'b0;
  int   tx_burst = 0;
  logic rx_steady = 1'b0;
  int   rx_left = 0;

  riscv_subset_core_step #(.DMEM_DEPTH(MEM_WORDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1);
    return {imm[11:5], rs2, rs1, rscs_pkg::F3_WORD, imm[4:0], rscs_pkg::OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rscs_pkg::OP_BRANCH};
  endfunction

  function automatic retire_t execute_word(input logic [31:0] w);
    retire_t     r;
    logic [31:0] a, b, imm_i, imm_s, imm_b, val, npc, addr;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic        wr, mw;
    r = '0;
    if (core_stopped || w == 32'd0) begin
      core_stopped = 1'b1;
      r.next_pc = core_pc;
      r.halted = 1'b1;
      n_halted++;
      return r;
    end
    a = core_regs[w[19:15]];
    b = core_regs[w[24:20]];
    f3 = w[14:12];
    f7 = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    npc = core_pc + 32'd4;
    rd = w[11:7];
    val = 32'd0;
    wr = 1'b0;
    mw = 1'b0;
    case (w[6:0])
      rscs_pkg::OP_REG: begin
        wr = 1'b1;
        if (f3 == rscs_pkg::F3_ADD && f7 == rscs_pkg::F7_BASE) val = a + b;
        else if (f3 == rscs_pkg::F3_ADD && f7 == rscs_pkg::F7_ALT) val = a - b;
        else if (f3 == rscs_pkg::F3_AND && f7 == rscs_pkg::F7_BASE) val = a & b;
        else if (f3 == rscs_pkg::F3_XOR && f7 == rscs_pkg::F7_BASE) val = a ^ b;
        else if (f3 == rscs_pkg::F3_SR && f7 == rscs_pkg::F7_ALT) val = $signed(a) >>> b[4:0];
        else wr = 1'b0;
      end
      rscs_pkg::OP_IMM: begin
        wr = 1'b1;
        if (f3 == rscs_pkg::F3_ADD) val = a + imm_i;
        else if (f3 == rscs_pkg::F3_AND) val = a & imm_i;
        else wr = 1'b0;
      end
      rscs_pkg::OP_LOAD: begin
        if (f3 == rscs_pkg::F3_WORD) begin
          addr = (a + imm_i) % MEM_WORDS;
          val = core_mem[addr];
          wr = 1'b1;
          n_loads++;
        end
      end
      rscs_pkg::OP_STORE: begin
        if (f3 == rscs_pkg::F3_WORD) begin
          addr = (a + imm_s) % MEM_WORDS;
          core_mem[addr] = b;
          mw = 1'b1;
          n_stores++;
        end
      end
      rscs_pkg::OP_BRANCH: begin
        if (f3 == rscs_pkg::F3_BLT && $signed(a) < $signed(b)) begin
          npc = core_pc + imm_b;
          n_taken++;
        end
      end
      rscs_pkg::OP_JALR: begin
        if (f3 == rscs_pkg::F3_JALR) begin
          val = core_pc + 32'd4;
          wr = 1'b1;
          npc = a + imm_i;
          n_jumps++;
        end
      end
      default: ;
    endcase
    if (wr && rd != 5'd0) begin
      core_regs[rd] = val;
      n_reg_writes++;
    end else begin
      wr = 1'b0;
      rd = 5'd0;
      val = 32'd0;
    end
    core_pc = npc;
    r.next_pc = npc;
    r.reg_written = wr;
    r.dest_index = rd;
    r.dest_value = val;
    r.mem_written = mw;
    return r;
  endfunction

  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] random_insn();
    insn_kind_t  kind;
    logic [4:0]  rd, rs1, rs2;
    logic [11:0] imm;
    logic [6:0]  f7r, opr;
    logic [2:0]  f3r;
    logic [31:0] w;
    kind = insn_kind_t'($urandom_range(0, K_NOISE));
    rd = pick_reg();
    rs1 = pick_reg();
    rs2 = pick_reg();
    imm = 12'($urandom);
    if ((kind == K_LW || kind == K_SW) && $urandom_range(0, 1)) begin
      rs1 = 5'd0;
      imm = 12'($urandom_range(0, 15));
    end
    f7r = 7'($urandom);
    f3r = 3'($urandom);
    case ($urandom_range(0, 5))
      0: opr = rscs_pkg::OP_REG;
      1: opr = rscs_pkg::OP_IMM;
      2: opr = rscs_pkg::OP_LOAD;
      3: opr = rscs_pkg::OP_STORE;
      4: opr = rscs_pkg::OP_BRANCH;
      default: opr = rscs_pkg::OP_JALR;
    endcase
    case (kind)
      K_ADD:   w = enc_r(rscs_pkg::F7_BASE, rs2, rs1, rscs_pkg::F3_ADD, rd, rscs_pkg::OP_REG);
      K_SUB:   w = enc_r(rscs_pkg::F7_ALT, rs2, rs1, rscs_pkg::F3_ADD, rd, rscs_pkg::OP_REG);
      K_AND:   w = enc_r(rscs_pkg::F7_BASE, rs2, rs1, rscs_pkg::F3_AND, rd, rscs_pkg::OP_REG);
      K_XOR:   w = enc_r(rscs_pkg::F7_BASE, rs2, rs1, rscs_pkg::F3_XOR, rd, rscs_pkg::OP_REG);
      K_SRA:   w = enc_r(rscs_pkg::F7_ALT, rs2, rs1, rscs_pkg::F3_SR, rd, rscs_pkg::OP_REG);
      K_ADDI:  w = enc_i(imm, rs1, rscs_pkg::F3_ADD, rd, rscs_pkg::OP_IMM);
      K_ANDI:  w = enc_i(imm, rs1, rscs_pkg::F3_AND, rd, rscs_pkg::OP_IMM);
      K_LW:    w = enc_i(imm, rs1, rscs_pkg::F3_WORD, rd, rscs_pkg::OP_LOAD);
      K_SW:    w = enc_s(imm, rs2, rs1);
      K_BLT:   w = enc_b({imm, 1'b0}, rs2, rs1, rscs_pkg::F3_BLT);
      K_JALR:  w = enc_i(imm, rs1, rscs_pkg::F3_JALR, rd, rscs_pkg::OP_JALR);
      K_ODD:   w = enc_r(f7r, rs2, rs1, f3r, rd, opr);
      default: begin
        w = $urandom;
        if (w == 32'd0) w = 32'd1;
      end
    endcase
    return w;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %08h, got %08h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : rx_check
    retire_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = retire_t'(out_tdata);
      if (retire_q.size() == 0) begin
        $error("result word with nothing pending: next_pc %08h", got.next_pc);
        mismatch_count++;
      end else begin
        want = retire_q.pop_front();
        compare_field("next_pc", want.next_pc, got.next_pc);
        compare_field("reg_written", 32'(want.reg_written), 32'(got.reg_written));
        compare_field("dest_index", 32'(want.dest_index), 32'(got.dest_index));
        compare_field("dest_value", want.dest_value, got.dest_value);
        compare_field("mem_written", 32'(want.mem_written), 32'(got.mem_written));
        compare_field("halted", 32'(want.halted), 32'(got.halted));
      end
    end
  end

  always @(posedge clk) begin
    if (rx_steady) begin
      out_tready <= 1'b1;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      out_tready <= ~out_tready;
      rx_left <= out_tready ? $urandom_range(0, 5) : $urandom_range(0, 11);
    end
  end

  task automatic drop_valid();
    if (!tx_low) begin
      in_tvalid <= 1'b0;
      tx_low = 1'b1;
    end
  endtask

  task automatic send_word(input logic [31:0] w);
    int gap;
    in_tdata <= w;
    if (tx_low) begin
      in_tvalid <= 1'b1;
      tx_low = 1'b0;
    end
    do @(posedge clk); while (!in_tready);
    retire_q.push_back(execute_word(w));
    words_sent++;
    if (!tx_steady) begin
      if (tx_burst == 0) begin
        tx_burst = $urandom_range(1, 16);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          drop_valid();
          repeat (gap) @(posedge clk);
        end
      end else begin
        tx_burst--;
      end
    end
  endtask

  task automatic drain_results();
    drop_valid();
    do @(posedge clk); while (retire_q.size() != 0);
  endtask

  task automatic test_alu_ops();
    send_word(enc_i(12'hFFF, 5'd0, rscs_pkg::F3_ADD, 5'd1, rscs_pkg::OP_IMM));
    send_word(enc_i(12'h7FF, 5'd0, rscs_pkg::F3_ADD, 5'd2, rscs_pkg::OP_IMM));
    send_word(enc_r(rscs_pkg::F7_BASE, 5'd2, 5'd1, rscs_pkg::F3_ADD, 5'd3, rscs_pkg::OP_REG));
    send_word(enc_r(rscs_pkg::F7_ALT, 5'd1, 5'd0, rscs_pkg::F3_ADD, 5'd4, rscs_pkg::OP_REG));
    send_word(enc_r(rscs_pkg::F7_BASE, 5'd2, 5'd1, rscs_pkg::F3_AND, 5'd5, rscs_pkg::OP_REG));
    send_word(enc_r(rscs_pkg::F7_BASE, 5'd2, 5'd1, rscs_pkg::F3_XOR, 5'd6, rscs_pkg::OP_REG));
    send_word(enc_r(rscs_pkg::F7_ALT, 5'd2, 5'd6, rscs_pkg::F3_SR, 5'd8, rscs_pkg::OP_REG));
    send_word(enc_r(rscs_pkg::F7_ALT, 5'd4, 5'd6, rscs_pkg::F3_SR, 5'd9, rscs_pkg::OP_REG));
    send_word(enc_i(12'h800, 5'd1, rscs_pkg::F3_AND, 5'd10, rscs_pkg::OP_IMM));
    send_word(enc_i(12'h005, 5'd1, rscs_pkg::F3_ADD, 5'd0, rscs_pkg::OP_IMM));
  endtask

  task automatic test_memory();
    send_word(enc_s(12'hFFF, 5'd2, 5'd0));
    send_word(enc_i(12'hFFF, 5'd0, rscs_pkg::F3_WORD, 5'd11, rscs_pkg::OP_LOAD));
    send_word(enc_i(12'h7FF, 5'd1, rscs_pkg::F3_WORD, 5'd12, rscs_pkg::OP_LOAD));
    send_word(enc_s(12'h000, 5'd6, 5'd6));
    send_word(enc_i(12'h000, 5'd6, rscs_pkg::F3_WORD, 5'd13, rscs_pkg::OP_LOAD));
    send_word(enc_i(12'h000, 5'd6, rscs_pkg::F3_WORD, 5'd0, rscs_pkg::OP_LOAD));
  endtask

  task automatic test_branches_and_jumps();
    send_word(enc_b(13'd8, 5'd2, 5'd1, rscs_pkg::F3_BLT));
    send_word(enc_b(13'd8, 5'd1, 5'd2, rscs_pkg::F3_BLT));
    send_word(enc_b(13'd8, 5'd1, 5'd1, rscs_pkg::F3_BLT));
    send_word(enc_b(13'h1000, 5'd2, 5'd1, rscs_pkg::F3_BLT));
    send_word(enc_b(13'h0FFE, 5'd4, 5'd6, rscs_pkg::F3_BLT));
    send_word(enc_i(12'hFFF, 5'd2, rscs_pkg::F3_JALR, 5'd14, rscs_pkg::OP_JALR));
    send_word(enc_i(12'h000, 5'd1, rscs_pkg::F3_JALR, 5'd1, rscs_pkg::OP_JALR));
  endtask

  task automatic test_unsupported_words();
    send_word(32'hFFFF_FFFF);
    send_word(enc_r(F7_ODD, 5'd2, 5'd1, rscs_pkg::F3_ADD, 5'd15, rscs_pkg::OP_REG));
    send_word(enc_i(12'h001, 5'd1, F3_SLL, 5'd15, rscs_pkg::OP_IMM));
    send_word(enc_i(12'h000, 5'd0, rscs_pkg::F3_JALR, 5'd0, rscs_pkg::OP_JALR));
  endtask

  task automatic test_random_program(input int count);
    repeat (count) send_word(random_insn());
  endtask

  task automatic test_back_to_back(input int count);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (count) send_word(random_insn());
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_halt();
    send_word(32'd0);
    send_word(enc_i(12'h123, 5'd0, rscs_pkg::F3_ADD, 5'd3, rscs_pkg::OP_IMM));
    send_word(32'hFFFF_FFFF);
    send_word(random_insn());
    send_word(32'd0);
  endtask

  initial begin
    core_pc = 32'd0;
    core_stopped = 1'b0;
    foreach (core_regs[i]) core_regs[i] = 32'd0;
    foreach (core_mem[i]) core_mem[i] = 32'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_alu_ops();
    test_memory();
    test_branches_and_jumps();
    test_unsupported_words();
    test_random_program(520);
    drain_results();
    test_random_program(300);
    test_back_to_back(250);
    test_random_program(50);
    test_halt();
    drain_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d words: %0d register writes, %0d loads, %0d stores,",
             words_sent, n_reg_writes, n_loads, n_stores);
    $display("  %0d taken branches, %0d jumps, %0d halted results.",
             n_taken, n_jumps, n_halted);
    if (mismatch_count == 0 && retire_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### riscv_subset_core_step.f
sv/rscs_pkg.sv
sv/rscs_ram.sv
sv/rscs_exec.sv
sv/riscv_subset_core_step.sv
sv/rscs_chk.sv
tb/sv/testbench.sv
